[rtl/alle_pkg.sv]
package alle_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ID_W        = 16;
  localparam int STATUS_W    = 8;
  localparam int HEAD_W      = 6;
  localparam int POS_W       = 6;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LINK_W      = ADDR_W + 1;
  localparam int DATA_W      = ID_W + STATUS_W;

  // Link value that marks the end of a list; also the "store full" pointer.
  localparam logic [LINK_W-1:0] END_LINK = LINK_W'(STORE_DEPTH);

  typedef enum logic [2:0] {
    FN_CREATE = 3'd0,
    FN_GET    = 3'd1,
    FN_APPEND = 3'd2,
    FN_DELETE = 3'd3,
    FN_INSERT = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    OC_OK       = 2'd0,
    OC_FULL     = 2'd1,
    OC_PAST_END = 2'd2,
    OC_NO_MATCH = 2'd3
  } outcome_t;

  typedef struct packed {
    func_t                func;
    logic [HEAD_W-1:0]    list_head;
    logic [POS_W-1:0]     position;
    logic [ID_W-1:0]      item_id;
    logic [STATUS_W-1:0]  item_status;
  } req_t;

  typedef struct packed {
    logic [HEAD_W-1:0]    new_head;
    logic [ID_W-1:0]      read_id;
    logic [STATUS_W-1:0]  read_status;
    outcome_t             outcome;
  } res_t;

  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 link_we;
    logic [LINK_W-1:0]    link_wdata;
    logic                 data_we;
    logic [DATA_W-1:0]    data_wdata;
  } mem_req_t;

  typedef struct packed {
    logic                 idle;
    logic [LINK_W-1:0]    free_ptr;
  } stat_t;

  // Any link at or past the depth reads as end of list.
  function automatic logic [LINK_W-1:0] clamp_link(input logic [LINK_W-1:0] v);
    clamp_link = (v >= END_LINK) ? END_LINK : v;
  endfunction

endpackage

[rtl/alle_ram.sv]
module alle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/alle_walker.sv]
module alle_walker import alle_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  req_t              req,
  input  logic [LINK_W-1:0] link_q,
  input  logic [DATA_W-1:0] data_q,
  output mem_req_t          mem,
  output logic              res_valid,
  output res_t              res,
  input  logic              res_ready,
  output stat_t             stat
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOOK = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_WR2  = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  res_t              res_r, res_nxt;
  logic [LINK_W-1:0] fp_r, fp_nxt;
  logic [ADDR_W-1:0] cur_r, cur_nxt;
  logic [ADDR_W-1:0] nx_r, nx_nxt;
  logic [LINK_W-1:0] cnt_r, cnt_nxt;

  logic full;
  logic head_ok;
  logic link_end;
  logic key_hit;

  assign full     = (fp_r == END_LINK);
  assign head_ok  = (LINK_W'(req.list_head) < fp_r);
  assign link_end = (link_q >= END_LINK);
  assign key_hit  = (data_q == {req_r.item_id, req_r.item_status});

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    fp_nxt    = fp_r;
    cur_nxt   = cur_r;
    nx_nxt    = nx_r;
    cnt_nxt   = cnt_r;
    mem       = '0;

    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          req_nxt         = req;
          res_nxt         = '0;
          res_nxt.outcome = OC_OK;
          cur_nxt         = ADDR_W'(req.list_head);
          cnt_nxt         = '0;
          mem.rd_addr     = ADDR_W'(req.list_head);
          state_nxt       = ST_RESP;
          case (req.func)
            FN_CREATE: begin
              if (full) begin
                res_nxt.outcome = OC_FULL;
              end else begin
                mem.link_we      = 1'b1;
                mem.wr_addr      = fp_r[ADDR_W-1:0];
                mem.link_wdata   = END_LINK;
                res_nxt.new_head = HEAD_W'(fp_r);
                fp_nxt           = fp_r + LINK_W'(1);
              end
            end
            FN_GET: begin
              if (!head_ok || req.position == '0) begin
                res_nxt.outcome = OC_PAST_END;
              end else begin
                mem.rd_en = 1'b1;
                state_nxt = ST_LOOK;
              end
            end
            FN_APPEND, FN_INSERT: begin
              if (full) begin
                res_nxt.outcome = OC_FULL;
              end else if (!head_ok) begin
                res_nxt.outcome = OC_PAST_END;
              end else begin
                mem.rd_en = 1'b1;
                state_nxt = ST_LOOK;
              end
            end
            FN_DELETE: begin
              if (!head_ok) begin
                res_nxt.outcome = OC_NO_MATCH;
              end else begin
                mem.rd_en = 1'b1;
                state_nxt = ST_LOOK;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      // link_q/data_q hold the entry at cur_r
      ST_LOOK: begin
        mem.rd_addr = link_q[ADDR_W-1:0];
        case (req_r.func)
          FN_GET: begin
            if (cnt_r == LINK_W'(req_r.position)) begin
              res_nxt.read_id     = data_q[DATA_W-1:STATUS_W];
              res_nxt.read_status = data_q[STATUS_W-1:0];
              state_nxt           = ST_RESP;
            end else if (link_end) begin
              res_nxt.outcome = OC_PAST_END;
              state_nxt       = ST_RESP;
            end else begin
              mem.rd_en = 1'b1;
              cur_nxt   = link_q[ADDR_W-1:0];
              cnt_nxt   = cnt_r + LINK_W'(1);
            end
          end
          FN_INSERT: begin
            if (cnt_r == LINK_W'(req_r.position)) begin
              mem.wr_addr    = fp_r[ADDR_W-1:0];
              mem.link_we    = 1'b1;
              mem.link_wdata = clamp_link(link_q);
              mem.data_we    = 1'b1;
              mem.data_wdata = {req_r.item_id, req_r.item_status};
              state_nxt      = ST_WR2;
            end else if (link_end) begin
              res_nxt.outcome = OC_PAST_END;
              state_nxt       = ST_RESP;
            end else begin
              mem.rd_en = 1'b1;
              cur_nxt   = link_q[ADDR_W-1:0];
              cnt_nxt   = cnt_r + LINK_W'(1);
            end
          end
          FN_APPEND: begin
            if (link_end || cnt_r == END_LINK) begin
              mem.wr_addr    = fp_r[ADDR_W-1:0];
              mem.link_we    = 1'b1;
              mem.link_wdata = END_LINK;
              mem.data_we    = 1'b1;
              mem.data_wdata = {req_r.item_id, req_r.item_status};
              state_nxt      = ST_WR2;
            end else begin
              mem.rd_en = 1'b1;
              cur_nxt   = link_q[ADDR_W-1:0];
              cnt_nxt   = cnt_r + LINK_W'(1);
            end
          end
          FN_DELETE: begin
            if (link_end) begin
              res_nxt.outcome = OC_NO_MATCH;
              state_nxt       = ST_RESP;
            end else begin
              mem.rd_en = 1'b1;
              nx_nxt    = link_q[ADDR_W-1:0];
              state_nxt = ST_SCAN;
            end
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end

      // cur_r is the predecessor, link_q/data_q hold the entry at nx_r
      ST_SCAN: begin
        mem.rd_addr = link_q[ADDR_W-1:0];
        if (key_hit) begin
          mem.wr_addr    = cur_r;
          mem.link_we    = 1'b1;
          mem.link_wdata = clamp_link(link_q);
          state_nxt      = ST_RESP;
        end else if (link_end || cnt_r == LINK_W'(STORE_DEPTH - 1)) begin
          res_nxt.outcome = OC_NO_MATCH;
          state_nxt       = ST_RESP;
        end else begin
          mem.rd_en = 1'b1;
          cur_nxt   = nx_r;
          nx_nxt    = link_q[ADDR_W-1:0];
          cnt_nxt   = cnt_r + LINK_W'(1);
        end
      end

      ST_WR2: begin
        mem.wr_addr    = cur_r;
        mem.link_we    = 1'b1;
        mem.link_wdata = fp_r;
        fp_nxt         = fp_r + LINK_W'(1);
        state_nxt      = ST_RESP;
      end

      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      fp_r    <= fp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
    cur_r <= cur_nxt;
    nx_r  <= nx_nxt;
    cnt_r <= cnt_nxt;
  end

  assign res_valid     = (state_r == ST_RESP);
  assign res           = res_r;
  assign stat.idle     = (state_r == ST_IDLE);
  assign stat.free_ptr = fp_r;

endmodule

[rtl/array_linked_list_engine.sv]
// Linked-list engine: many singly linked lists share one 64-node store.
// Input channel (in_*): one request per transfer. in_tuser carries the
// operation (create, get, append, delete, insert); in_tdata carries the
// list head, position, item id and item status.
// Result channel (out_*): exactly one transfer per request, in request
// order. out_tuser carries the outcome code (ok, store full, position past
// end, no match); out_tdata carries the new head and the element read.
// Walk: the sequencer works one request at a time and follows one link
// per cycle through the node RAMs (registered read). Create and early
// errors answer without a walk; get and insert walk to the position,
// append to the list end and delete until the key matches or the list
// ends. That link walk sets the rate.
// Reset (synchronous, rst_n low) empties the store by clearing the free
// pointer; node contents stay undefined until allocated.
// Stall: a finished result sits in the output register while the next
// request is taken; if the result register is still full when the next
// one completes, the sequencer holds it and accepts nothing new.
module array_linked_list_engine import alle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // list_head[5:0], position[11:6], item_id[27:12],
                                  // item_status[35:28], zero pad[39:36]
  input  logic [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // new_head[5:0], read_id[21:6], read_status[29:22],
                                  // zero pad[31:30]
  output logic [1:0]  out_tuser   // outcome[1:0]
);

  req_t              req;
  mem_req_t          mem;
  res_t              res;
  stat_t             stat;
  logic              res_valid;
  logic              res_ready;
  logic [LINK_W-1:0] link_q;
  logic [DATA_W-1:0] data_q;

  logic              out_valid_r;
  res_t              out_res_r;

  // Unpack the request
  assign req.func        = func_t'(in_tuser);
  assign req.list_head   = in_tdata[5:0];
  assign req.position    = in_tdata[11:6];
  assign req.item_id     = in_tdata[27:12];
  assign req.item_status = in_tdata[35:28];

  // Take a request only while the sequencer is idle
  assign in_tready = stat.idle;

  alle_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req       (req),
    .link_q    (link_q),
    .data_q    (data_q),
    .mem       (mem),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .stat      (stat)
  );

  // Next-node links; a write never targets an entry read in the same
  // request after it, so no forwarding is needed.
  alle_ram #(.WIDTH(LINK_W), .DEPTH(STORE_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (mem.link_we),
    .waddr (mem.wr_addr),
    .wdata (mem.link_wdata),
    .re    (mem.rd_en),
    .raddr (mem.rd_addr),
    .rdata (link_q)
  );

  // Element payload {id, status}
  alle_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (mem.data_we),
    .waddr (mem.wr_addr),
    .wdata (mem.data_wdata),
    .re    (mem.rd_en),
    .raddr (mem.rd_addr),
    .rdata (data_q)
  );

  // Output register: load when empty or draining this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.read_status, out_res_r.read_id, out_res_r.new_head};
  assign out_tuser  = out_res_r.outcome;

  // Free pointer never runs past the store
  assert property (@(posedge clk) disable iff (!rst_n)
    stat.free_ptr <= END_LINK)
    else $error("free pointer beyond store depth");

  // An accepted request always leaves the sequencer busy
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !stat.idle)
    else $error("sequencer idle right after accept");

  // Store-full answers only when every node is handed out
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.outcome == OC_FULL |-> stat.free_ptr == END_LINK)
    else $error("store full reported with free nodes left");

  // A result handed to the output register shows up there
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_tvalid)
    else $error("result lost on its way to the output register");

endmodule
